/* rtl/scc_pkg.sv */
// Shared types and constants for the strongly connected components block.
`timescale 1ns / 1ps
package scc_pkg;

   // Fixed widths of the transaction fields and of the vertex count register.
   localparam int VERTEX_W = 6;
   localparam int VC_W     = 7;
   localparam logic [VC_W-1:0] VC_RESET = 7'd64;

   // Request operation codes.
   localparam logic OP_ADD_EDGE = 1'b0;
   localparam logic OP_COMPUTE  = 1'b1;

   typedef struct packed {
      logic                opcode;
      logic [VERTEX_W-1:0] edge_from;
      logic [VERTEX_W-1:0] edge_to;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] member_vertex;
      logic                component_last;
      logic                run_last;
      logic                edges_dropped;
   } rsp_type;

   // One result handed from the search engine to the output register.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

endpackage

/* rtl/scc_core.sv */
// Search engine: edge store, two depth-first passes and component emission.
`timescale 1ns / 1ps
module scc_core
   import scc_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [VC_W-1:0] nv,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   output emit_type        emit,
   input  logic            emit_ready
);

   localparam int VI = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int NW = $clog2(MAX_VERTICES + 1);
   localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ET = $clog2(MAX_EDGES + 1);
   localparam int SW = VI + ET;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_ROOT1, ST_ROOT1_WAIT, ST_ROOT2, ST_ROOT2_WAIT, ST_ROOT2_VIS,
      ST_SCAN, ST_SCAN_VIS, ST_SCAN_CHECK, ST_POP_WAIT,
      ST_EM_OUTER, ST_EM_LAB, ST_EM_ISSUE, ST_EM_CHECK, ST_EM_END
   } state_type;

   state_type             state_ff, state_in;
   state_type             clr_next_ff, clr_next_in;
   logic                  pass2_ff, pass2_in;
   logic [NW-1:0]         clr_ff, clr_in;
   logic [NW-1:0]         rcnt_ff, rcnt_in;
   logic [NW-1:0]         k_ff, k_in;
   logic [NW-1:0]         fin_ff, fin_in;
   logic [NW-1:0]         u_ff, u_in;
   logic [NW-1:0]         out_cnt_ff, out_cnt_in;
   logic [VI-1:0]         top_v_ff, top_v_in;
   logic [ET-1:0]         top_pos_ff, top_pos_in;
   logic [VI-1:0]         sp_ff, sp_in;
   logic [VI-1:0]         root_v_ff, root_v_in;
   logic [VI-1:0]         lab_ff, lab_in;
   logic [VI-1:0]         pend_ff, pend_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [ET-1:0]         edge_total_ff, edge_total_in;
   logic                  drop_ff, drop_in;

   // Memories and their registered read data.
   logic [2*VERTEX_W-1:0] edge_mem [MAX_EDGES];
   logic [SW-1:0]         stack_mem [MAX_VERTICES];
   logic [VI-1:0]         fin_mem [MAX_VERTICES];
   logic [VI-1:0]         lab_mem [MAX_VERTICES];
   logic                  vis_mem [MAX_VERTICES];
   logic [2*VERTEX_W-1:0] edge_rd_ff;
   logic [SW-1:0]         stack_rd_ff;
   logic [VI-1:0]         fin_rd_ff;
   logic [VI-1:0]         lab_rd_ff;
   logic                  vis_rd_ff;

   logic                  edge_we, edge_re, stack_we, stack_re;
   logic                  fin_we, fin_re, lab_we, lab_re, vis_we, vis_re;
   logic [EA-1:0]         edge_wa, edge_ra;
   logic [2*VERTEX_W-1:0] edge_wd;
   logic [VI-1:0]         stack_wa, stack_ra, fin_wa, fin_ra, lab_wa, lab_ra;
   logic [VI-1:0]         vis_wa, vis_ra;
   logic [SW-1:0]         stack_wd;
   logic [VI-1:0]         fin_wd, lab_wd;
   logic                  vis_wd;

   logic [NW-1:0]         nv_n;
   logic [VERTEX_W-1:0]   e_src, e_dst, here, there;
   logic                  edge_ok;
   logic [NW-1:0]         k_dec;
   logic [VI-1:0]         sp_dec;

   assign nv_n   = nv[NW-1:0];
   assign e_src  = edge_rd_ff[2*VERTEX_W-1:VERTEX_W];
   assign e_dst  = edge_rd_ff[VERTEX_W-1:0];
   assign here   = pass2_ff ? e_dst : e_src;
   assign there  = pass2_ff ? e_src : e_dst;
   assign edge_ok = ({1'b0, e_src} < nv) && ({1'b0, e_dst} < nv);
   assign k_dec  = k_ff - 1'b1;
   assign sp_dec = sp_ff - 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   // Next-state and memory control.
   always_comb begin
      state_in      = state_ff;
      clr_next_in   = clr_next_ff;
      pass2_in      = pass2_ff;
      clr_in        = clr_ff;
      rcnt_in       = rcnt_ff;
      k_in          = k_ff;
      fin_in        = fin_ff;
      u_in          = u_ff;
      out_cnt_in    = out_cnt_ff;
      top_v_in      = top_v_ff;
      top_pos_in    = top_pos_ff;
      sp_in         = sp_ff;
      root_v_in     = root_v_ff;
      lab_in        = lab_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      edge_total_in = edge_total_ff;
      drop_in       = drop_ff;
      edge_we  = 1'b0;
      edge_re  = 1'b0;
      stack_we = 1'b0;
      stack_re = 1'b0;
      fin_we   = 1'b0;
      fin_re   = 1'b0;
      lab_we   = 1'b0;
      lab_re   = 1'b0;
      vis_we   = 1'b0;
      vis_re   = 1'b0;
      edge_wa  = edge_total_ff[EA-1:0];
      edge_wd  = {req_data.edge_from, req_data.edge_to};
      edge_ra  = top_pos_ff[EA-1:0];
      stack_wa = sp_ff;
      stack_wd = {top_v_ff, top_pos_ff + 1'b1};
      stack_ra = sp_dec;
      fin_wa   = fin_ff[VI-1:0];
      fin_wd   = top_v_ff;
      fin_ra   = k_dec[VI-1:0];
      lab_wa   = there[VI-1:0];
      lab_wd   = root_v_ff;
      lab_ra   = u_ff[VI-1:0];
      vis_wa   = there[VI-1:0];
      vis_wd   = 1'b1;
      vis_ra   = there[VI-1:0];
      emit.valid = 1'b0;
      emit.data.member_vertex  = VERTEX_W'(pend_ff);
      emit.data.component_last = 1'b0;
      emit.data.run_last       = 1'b0;
      emit.data.edges_dropped  = drop_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.opcode == OP_COMPUTE) begin
                  rcnt_in     = '0;
                  fin_in      = '0;
                  out_cnt_in  = '0;
                  pass2_in    = 1'b0;
                  clr_in      = '0;
                  clr_next_in = ST_ROOT1;
                  state_in    = ST_CLEAR;
               end else if (edge_total_ff >= ET'(MAX_EDGES) ||
                            {1'b0, req_data.edge_from} >= nv ||
                            {1'b0, req_data.edge_to} >= nv) begin
                  drop_in = 1'b1;
               end else begin
                  edge_we       = 1'b1;
                  edge_total_in = edge_total_ff + 1'b1;
               end
            end
         end
         // Sweep the visited marks of the live vertices back to zero.
         ST_CLEAR: begin
            if (clr_ff == nv_n) begin
               state_in = clr_next_ff;
            end else begin
               vis_we = 1'b1;
               vis_wa = clr_ff[VI-1:0];
               vis_wd = 1'b0;
               clr_in = clr_ff + 1'b1;
            end
         end
         // Pass one roots: vertices in ascending order.
         ST_ROOT1: begin
            if (rcnt_ff == nv_n) begin
               k_in        = fin_ff;
               pass2_in    = 1'b1;
               clr_in      = '0;
               clr_next_in = ST_ROOT2;
               state_in    = ST_CLEAR;
            end else begin
               vis_re   = 1'b1;
               vis_ra   = rcnt_ff[VI-1:0];
               state_in = ST_ROOT1_WAIT;
            end
         end
         ST_ROOT1_WAIT: begin
            if (vis_rd_ff) begin
               rcnt_in  = rcnt_ff + 1'b1;
               state_in = ST_ROOT1;
            end else begin
               vis_we     = 1'b1;
               vis_wa     = rcnt_ff[VI-1:0];
               top_v_in   = rcnt_ff[VI-1:0];
               top_pos_in = '0;
               sp_in      = '0;
               state_in   = ST_SCAN;
            end
         end
         // Pass two roots: reverse finish order.
         ST_ROOT2: begin
            if (k_ff == '0) begin
               rcnt_in     = '0;
               clr_in      = '0;
               clr_next_in = ST_EM_OUTER;
               state_in    = ST_CLEAR;
            end else begin
               fin_re   = 1'b1;
               k_in     = k_dec;
               state_in = ST_ROOT2_WAIT;
            end
         end
         ST_ROOT2_WAIT: begin
            vis_re   = 1'b1;
            vis_ra   = fin_rd_ff;
            state_in = ST_ROOT2_VIS;
         end
         ST_ROOT2_VIS: begin
            if (vis_rd_ff) begin
               state_in = ST_ROOT2;
            end else begin
               vis_we     = 1'b1;
               vis_wa     = fin_rd_ff;
               lab_we     = 1'b1;
               lab_wa     = fin_rd_ff;
               lab_wd     = fin_rd_ff;
               root_v_in  = fin_rd_ff;
               top_v_in   = fin_rd_ff;
               top_pos_in = '0;
               sp_in      = '0;
               state_in   = ST_SCAN;
            end
         end
         // Fetch the next edge of the top vertex, or pop it when exhausted.
         ST_SCAN: begin
            if (top_pos_ff >= edge_total_ff) begin
               if (!pass2_ff) begin
                  fin_we = 1'b1;
                  fin_in = fin_ff + 1'b1;
               end
               if (sp_ff == '0) begin
                  if (pass2_ff) begin
                     state_in = ST_ROOT2;
                  end else begin
                     rcnt_in  = rcnt_ff + 1'b1;
                     state_in = ST_ROOT1;
                  end
               end else begin
                  stack_re = 1'b1;
                  sp_in    = sp_dec;
                  state_in = ST_POP_WAIT;
               end
            end else begin
               edge_re  = 1'b1;
               state_in = ST_SCAN_VIS;
            end
         end
         // An edge leaving the top vertex needs the mark of its far end.
         ST_SCAN_VIS: begin
            if (edge_ok && here == VERTEX_W'(top_v_ff)) begin
               vis_re   = 1'b1;
               state_in = ST_SCAN_CHECK;
            end else begin
               top_pos_in = top_pos_ff + 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN_CHECK: begin
            if (!vis_rd_ff) begin
               stack_we   = 1'b1;
               sp_in      = sp_ff + 1'b1;
               vis_we     = 1'b1;
               lab_we     = pass2_ff;
               top_v_in   = there[VI-1:0];
               top_pos_in = '0;
            end else begin
               top_pos_in = top_pos_ff + 1'b1;
            end
            state_in = ST_SCAN;
         end
         ST_POP_WAIT: begin
            top_v_in   = stack_rd_ff[SW-1:ET];
            top_pos_in = stack_rd_ff[ET-1:0];
            state_in   = ST_SCAN;
         end
         // Find the smallest vertex not yet emitted; it opens a component.
         ST_EM_OUTER: begin
            if (rcnt_ff == nv_n) begin
               edge_total_in = '0;
               drop_in       = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               lab_re   = 1'b1;
               lab_ra   = rcnt_ff[VI-1:0];
               vis_re   = 1'b1;
               vis_ra   = rcnt_ff[VI-1:0];
               state_in = ST_EM_LAB;
            end
         end
         ST_EM_LAB: begin
            if (vis_rd_ff) begin
               rcnt_in  = rcnt_ff + 1'b1;
               state_in = ST_EM_OUTER;
            end else begin
               lab_in   = lab_rd_ff;
               u_in     = rcnt_ff;
               state_in = ST_EM_ISSUE;
            end
         end
         ST_EM_ISSUE: begin
            if (u_ff == nv_n) begin
               state_in = ST_EM_END;
            end else begin
               lab_re   = 1'b1;
               state_in = ST_EM_CHECK;
            end
         end
         // Members are held one step so the last one can be flagged.
         ST_EM_CHECK: begin
            if (lab_rd_ff == lab_ff) begin
               if (!pend_valid_ff || emit_ready) begin
                  emit.valid = pend_valid_ff;
                  if (pend_valid_ff) begin
                     out_cnt_in = out_cnt_ff + 1'b1;
                  end
                  pend_in       = u_ff[VI-1:0];
                  pend_valid_in = 1'b1;
                  vis_we   = 1'b1;
                  vis_wa   = u_ff[VI-1:0];
                  u_in     = u_ff + 1'b1;
                  state_in = ST_EM_ISSUE;
               end
            end else begin
               u_in     = u_ff + 1'b1;
               state_in = ST_EM_ISSUE;
            end
         end
         ST_EM_END: begin
            emit.valid = 1'b1;
            emit.data.component_last = 1'b1;
            emit.data.run_last = (out_cnt_ff + 1'b1 == nv_n);
            if (emit_ready) begin
               out_cnt_in    = out_cnt_ff + 1'b1;
               pend_valid_in = 1'b0;
               rcnt_in       = rcnt_ff + 1'b1;
               if (out_cnt_ff + 1'b1 == nv_n) begin
                  edge_total_in = '0;
                  drop_in       = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_EM_OUTER;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pass2_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         edge_total_ff <= '0;
         drop_ff       <= 1'b0;
         out_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         pass2_ff      <= pass2_in;
         pend_valid_ff <= pend_valid_in;
         edge_total_ff <= edge_total_in;
         drop_ff       <= drop_in;
         out_cnt_ff    <= out_cnt_in;
      end
      clr_next_ff <= clr_next_in;
      clr_ff      <= clr_in;
      rcnt_ff     <= rcnt_in;
      k_ff        <= k_in;
      fin_ff      <= fin_in;
      u_ff        <= u_in;
      top_v_ff    <= top_v_in;
      top_pos_ff  <= top_pos_in;
      sp_ff       <= sp_in;
      root_v_ff   <= root_v_in;
      lab_ff      <= lab_in;
      pend_ff     <= pend_in;
   end

   // Edge store.
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wa] <= edge_wd;
      end
      if (edge_re) begin
         edge_rd_ff <= edge_mem[edge_ra];
      end
   end

   // Search stack holds the vertex and resume position of each lower entry.
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[stack_ra];
      end
   end

   // Finish order of pass one.
   always_ff @(posedge clock) begin
      if (fin_we) begin
         fin_mem[fin_wa] <= fin_wd;
      end
      if (fin_re) begin
         fin_rd_ff <= fin_mem[fin_ra];
      end
   end

   // Component labels from pass two.
   always_ff @(posedge clock) begin
      if (lab_we) begin
         lab_mem[lab_wa] <= lab_wd;
      end
      if (lab_re) begin
         lab_rd_ff <= lab_mem[lab_ra];
      end
   end

   // Visited marks, swept to zero before each pass and before emission.
   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[vis_wa] <= vis_wd;
      end
      if (vis_re) begin
         vis_rd_ff <= vis_mem[vis_ra];
      end
   end

endmodule

/* rtl/strongly_connected_components.sv */
// Top level: vertex count register, search engine and result output register.
// An edge transaction is accepted while the engine is idle. A compute transaction sweeps the
// visited marks three times and runs two depth-first passes, in which every vertex
// scans the whole edge store.
// Emitting the V results reads the component labels and can stall on the result output.
// Synchronous active-high reset clears the edge count, drop flag, vertex count (to 64).
`timescale 1ns / 1ps
module strongly_connected_components
   import scc_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [VC_W-1:0] csr_data
);

   logic [VC_W-1:0] vcount_ff, nv;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;
   emit_type        emit;
   logic            out_free;

   assign csr_ready = 1'b1;

   // Vertex count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VC_RESET;
      end else if (csr_valid) begin
         vcount_ff <= csr_data;
      end
   end

   // Clamp the count into the supported range.
   always_comb begin
      priority if (vcount_ff == '0) begin
         nv = VC_W'(1);
      end else if (vcount_ff > VC_W'(MAX_VERTICES)) begin
         nv = VC_W'(MAX_VERTICES);
      end else begin
         nv = vcount_ff;
      end
   end

   scc_core #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .nv         (nv),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .emit       (emit),
      .emit_ready (out_free)
   );

   // Output register for result transactions.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit.valid;
      end
      if (out_free && emit.valid) begin
         rsp_data_ff <= emit.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/scc_checker.sv */
// Port-level assertions for the strongly connected components block.
`timescale 1ns / 1ps
module scc_checker
   import scc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result transaction holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // The end of a run is always the end of a component.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.run_last || rsp_data.component_last))
      else $error("run end without component end");

   // A compute transaction blocks further requests.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.opcode == OP_COMPUTE |=> !req_ready)
      else $error("request taken during compute");

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* verif/strongly_connected_components_checker.sv */
// Checker for the strongly connected components block: predicts and compares results.
`timescale 1ns / 1ps
module strongly_connected_components_checker
   import scc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_type         req_data,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_type         rsp_data,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [VC_W-1:0] csr_data,
   output int              fail_count,
   output int              pending
);

   localparam int NV_MAX = 64;
   localparam int NE_MAX = 256;

   // Predictor state: vertex count register, edge store and drop flag.
   int                  vc_reg;
   logic [VERTEX_W-1:0] src_store [NE_MAX];
   logic [VERTEX_W-1:0] dst_store [NE_MAX];
   int                  stored_edges;
   bit                  drop_flag;

   // Working storage of the two searches.
   bit                  seen [NV_MAX];
   int                  scan_at [NV_MAX];
   int                  dfs_stack [NV_MAX];
   int                  finish_seq [NV_MAX];
   int                  comp_root [NV_MAX];

   rsp_type             expected_members [$];
   int                  mismatches;

   function automatic int live_count();
      int v;
      v = vc_reg;
      if (v < 1) v = 1;
      if (v > NV_MAX) v = NV_MAX;
      return v;
   endfunction

   // Next unvisited neighbour of v from its scan position, or -1.
   function automatic int next_unvisited(int v, int nv, bit rev);
      int e;
      int s;
      int t;
      int here;
      int there;
      for (e = scan_at[v]; e < stored_edges; e++) begin
         s = src_store[e];
         t = dst_store[e];
         here = rev ? t : s;
         there = rev ? s : t;
         if (s >= nv || t >= nv) continue;
         if (here == v && !seen[there]) begin
            scan_at[v] = e + 1;
            return there;
         end
      end
      scan_at[v] = stored_edges;
      return -1;
   endfunction

   // Depth-first search; forward records finish order, reverse labels by root.
   function automatic void search_tree(int root, int nv, bit rev, inout int finished);
      int sp;
      int v;
      int w;
      sp = 0;
      seen[root] = 1;
      scan_at[root] = 0;
      if (rev) comp_root[root] = root;
      dfs_stack[sp++] = root;
      while (sp > 0) begin
         v = dfs_stack[sp-1];
         w = next_unvisited(v, nv, rev);
         if (w >= 0 && sp < NV_MAX) begin
            seen[w] = 1;
            scan_at[w] = 0;
            if (rev) comp_root[w] = root;
            dfs_stack[sp++] = w;
         end else begin
            sp--;
            if (!rev && finished < NV_MAX) begin
               finish_seq[finished] = v;
               finished++;
            end
         end
      end
   endfunction

   // Runs both passes and queues one expected member per vertex.
   function automatic void predict_components();
      int      nv;
      int      finished;
      int      k;
      int      v;
      int      u;
      int      r;
      int      low [NV_MAX];
      int      last_idx;
      rsp_type m;
      nv = live_count();
      finished = 0;
      foreach (seen[i]) seen[i] = 0;
      for (v = 0; v < nv; v++)
         if (!seen[v]) search_tree(v, nv, 1'b0, finished);
      foreach (seen[i]) seen[i] = 0;
      for (k = finished; k > 0; k--) begin
         r = finish_seq[k-1];
         if (r < nv && !seen[r]) search_tree(r, nv, 1'b1, finished);
      end
      foreach (low[i]) low[i] = 63;
      for (v = nv; v > 0; v--) low[comp_root[v-1]] = v - 1;
      for (v = 0; v < nv; v++) comp_root[v] = low[comp_root[v]];
      for (v = 0; v < nv; v++) begin
         if (comp_root[v] != v) continue;
         last_idx = -1;
         for (u = v; u < nv; u++) begin
            if (comp_root[u] != v) continue;
            m.member_vertex  = u[VERTEX_W-1:0];
            m.component_last = 1'b0;
            m.run_last       = 1'b0;
            m.edges_dropped  = drop_flag;
            expected_members = {expected_members, m};
            last_idx = expected_members.size() - 1;
         end
         if (last_idx >= 0) expected_members[last_idx].component_last = 1'b1;
      end
      expected_members[expected_members.size()-1].run_last = 1'b1;
      stored_edges = 0;
      drop_flag = 0;
   endfunction

   // Track every transaction on the three channels.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         vc_reg = VC_RESET;
         stored_edges = 0;
         drop_flag = 0;
         mismatches = 0;
         expected_members.delete();
      end else begin
         if (csr_valid && csr_ready) vc_reg = csr_data;
         if (req_valid && req_ready) begin
            if (req_data.opcode == OP_COMPUTE) begin
               predict_components();
            end else if (stored_edges >= NE_MAX || req_data.edge_from >= live_count()
                         || req_data.edge_to >= live_count()) begin
               drop_flag = 1;
            end else begin
               src_store[stored_edges] = req_data.edge_from;
               dst_store[stored_edges] = req_data.edge_to;
               stored_edges++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_members.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result: vertex %0d last %b run %b drop %b",
                           rsp_data.member_vertex, rsp_data.component_last,
                           rsp_data.run_last, rsp_data.edges_dropped);
            end else begin
               want = expected_members.pop_front();
               if (want !== rsp_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"Mismatch: expected vertex %0d last %b run %b drop %b,",
                               " got %0d %b %b %b"},
                              want.member_vertex, want.component_last, want.run_last,
                              want.edges_dropped, rsp_data.member_vertex,
                              rsp_data.component_last, rsp_data.run_last,
                              rsp_data.edges_dropped);
               end
            end
         end
      end
      fail_count <= mismatches;
      pending <= expected_members.size();
   end

endmodule

/* verif/strongly_connected_components_tb.sv */
// Testbench top: stimulus, clocking and verdict for the strongly connected components block.
`timescale 1ns / 1ps
module strongly_connected_components_tb;
   import scc_pkg::*;

   localparam int STALL_LIMIT = 500000;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_type         req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_type         rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   logic [VC_W-1:0] csr_data;
   int              fail_count;
   int              pending;
   bit              quiet;
   int              hold_left;
   int              idle_cycles;

   strongly_connected_components DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   strongly_connected_components_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Result side backpressure in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         hold_left <= $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on cycles in which no transaction completes.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Present one request transaction and hold it until accepted.
   task automatic send_req(logic op, logic [VERTEX_W-1:0] from_v, logic [VERTEX_W-1:0] to_v);
      req_type r;
      r.opcode = op;
      r.edge_from = from_v;
      r.edge_to = to_v;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic add_edge(int from_v, int to_v);
      send_req(OP_ADD_EDGE, from_v[VERTEX_W-1:0], to_v[VERTEX_W-1:0]);
   endtask

   task automatic compute_run();
      send_req(OP_COMPUTE, VERTEX_W'($urandom), VERTEX_W'($urandom));
   endtask

   // Let the block drain before touching the vertex count.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_vertex_count(int value);
      csr_valid <= 1'b1;
      csr_data <= value[VC_W-1:0];
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int nv;
      int n_edges;
      int phase;
      int pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      quiet = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset vertex count: two-vertex cycles at both ends and a self loop.
      add_edge(0, 1);
      add_edge(1, 0);
      add_edge(63, 62);
      add_edge(62, 63);
      add_edge(5, 5);
      send_req(OP_COMPUTE, 6'h3f, 6'h3f);
      wait_idle();

      // A count of zero acts as one vertex; out-of-range endpoint is dropped.
      write_vertex_count(0);
      add_edge(0, 0);
      add_edge(1, 0);
      send_req(OP_COMPUTE, 6'h00, 6'h00);
      wait_idle();

      // A count above the maximum acts as the maximum.
      write_vertex_count(127);
      add_edge(63, 0);
      add_edge(0, 63);
      compute_run();
      wait_idle();

      // Count lowered after loading, then a run over an empty store.
      write_vertex_count(20);
      add_edge(10, 15);
      add_edge(15, 10);
      add_edge(3, 18);
      add_edge(2, 3);
      wait_idle();
      write_vertex_count(8);
      compute_run();
      compute_run();
      wait_idle();

      // Random graphs, mostly small, with some out-of-range noise.
      for (phase = 0; phase < 12; phase++) begin
         if (phase >= 9) quiet = 1;
         pick = $urandom_range(0, 9);
         if (pick < 6) nv = $urandom_range(2, 12);
         else if (pick == 6) nv = $urandom_range(0, 1);
         else if (pick == 7) nv = $urandom_range(13, 40);
         else nv = $urandom_range(64, 127);
         write_vertex_count(nv);
         if (nv < 1) nv = 1;
         if (nv > 64) nv = 64;
         n_edges = $urandom_range(0, 16);
         for (int i = 0; i < n_edges; i++) begin
            if ($urandom_range(0, 6) == 0)
               add_edge($urandom_range(0, 63), $urandom_range(0, 63));
            else
               add_edge($urandom_range(0, nv - 1), $urandom_range(0, nv - 1));
         end
         compute_run();
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
